>>> rtl/core/cmbf_pkg.sv
// Shared types and constants for the multichannel comb filter.
`timescale 1ns / 1ps

package cmbf_pkg;

   // Sample format: signed Q1.15
   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 3;
   localparam int FRAC_W   = SAMPLE_W - 1;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int Q_W      = PROD_W + 1 - FRAC_W;
   localparam int SUM_W    = Q_W + 1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Configuration register widths
   localparam int GAIN_W  = 16;
   localparam int DLEN_W  = 11;
   localparam int NCH_W   = 4;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Output queue
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

   typedef enum logic {
      MODE_FIR = 1'b0,
      MODE_IIR = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE         = 2'd0,
      CSR_GAIN         = 2'd1,
      CSR_DELAY_LEN    = 2'd2,
      CSR_NUM_CHANNELS = 2'd3
   } csr_idx_type;

   typedef struct packed {
      mode_type                   mode;
      logic signed [GAIN_W-1:0]   gain;
      logic        [DLEN_W-1:0]   delay_len;
      logic        [NCH_W-1:0]    num_channels;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic        [CHAN_W-1:0]   channel;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       last_out;
      logic                       channel_error;
   } rsp_type;

   // Beat state handed from the address stage to the multiply-add stage
   typedef struct packed {
      logic                       valid;
      logic                       err;
      logic                       live;   // delayed entry was written since reset
      logic                       last;
      logic signed [SAMPLE_W-1:0] sample;
   } stage_type;

endpackage

>>> rtl/core/cmbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cmbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cmbf_addr.sv
// Pointer stage: per-channel write pointer update, channel check, delay line addresses.
`timescale 1ns / 1ps

module cmbf_addr import cmbf_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_DELAY    = 1024,
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int PTR_W = $clog2(MAX_DELAY),
   localparam int AW    = $clog2(MAX_CHANNELS * MAX_DELAY)
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  req_type      req,
   output logic         s1_busy,
   output logic [AW-1:0] dly_rd_addr,
   output stage_type    s2,
   output logic [AW-1:0] s2_raddr,
   output logic [AW-1:0] s2_waddr
);

   localparam int CMP_W = (PTR_W + 1 > DLEN_W) ? PTR_W + 1 : DLEN_W;
   localparam logic [CMP_W-1:0] MAXD   = CMP_W'(MAX_DELAY);
   localparam logic [PTR_W:0]   MAXD_P = (PTR_W + 1)'(MAX_DELAY);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_DELAY - 1);
   localparam logic [6:0]       MAXC   = 7'(MAX_CHANNELS);

   // stage 1 registers
   logic               s1_valid_ff;
   req_type            s1_req_ff;
   logic               s1_pvalid_ff;
   logic [MAX_CHANNELS-1:0] pvalid_ff;

   // last pointer write, for back-to-back beats on one channel
   logic               pw_valid_ff;
   logic [CH_W-1:0]    pw_ch_ff;
   logic [PTR_W:0]     pw_ptr_ff;

   stage_type          s2_ff, s2_in;
   logic [AW-1:0]      s2_raddr_ff, s2_waddr_ff;

   logic [CH_W-1:0]    rd_ch, s1_ch;
   logic [PTR_W:0]     ptr_rdata, ptr_cur, ptr_next;
   logic [PTR_W-1:0]   wp, wp_next, rp;
   logic               wrapped, at_last;
   logic [PTR_W:0]     wp_ext, dl, rp_full;
   logic [CMP_W-1:0]   dlen_ext;
   logic [6:0]         active;
   logic               err, ptr_we;
   logic [AW-1:0]      base, raddr, waddr;

   assign rd_ch = CH_W'(req.channel);
   assign s1_ch = CH_W'(s1_req_ff.channel);

   cmbf_ram #(
      .WIDTH (PTR_W + 1),
      .DEPTH (MAX_CHANNELS)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_we),
      .wr_addr (s1_ch),
      .wr_data (ptr_next),
      .rd_addr (rd_ch),
      .rd_data (ptr_rdata)
   );

   // channel check against the active count
   always_comb begin
      active = ({3'b0, cfg.num_channels} > MAXC) ? MAXC : {3'b0, cfg.num_channels};
      err    = ({4'b0, s1_req_ff.channel} >= active);
   end

   // effective delay: zero acts as one, clamp to line length
   always_comb begin
      dlen_ext = CMP_W'(cfg.delay_len);
      if (dlen_ext == '0) begin
         dl = (PTR_W + 1)'(1);
      end else if (dlen_ext > MAXD) begin
         dl = MAXD_P;
      end else begin
         dl = (PTR_W + 1)'(dlen_ext);
      end
   end

   // pointer select: forwarded write, stored value, or reset value
   always_comb begin
      priority if (pw_valid_ff && (pw_ch_ff == s1_ch)) begin
         ptr_cur = pw_ptr_ff;
      end else if (s1_pvalid_ff) begin
         ptr_cur = ptr_rdata;
      end else begin
         ptr_cur = '0;
      end
      wrapped = ptr_cur[PTR_W];
      wp      = ptr_cur[PTR_W-1:0];
   end

   // read position and addresses
   always_comb begin
      wp_ext = {1'b0, wp};
      if (wp_ext >= dl) begin
         rp_full = wp_ext - dl;
      end else begin
         rp_full = wp_ext + MAXD_P - dl;
      end
      rp    = rp_full[PTR_W-1:0];
      base  = AW'(s1_ch) * AW'(MAX_DELAY);
      raddr = base + AW'(rp);
      waddr = base + AW'(wp);
   end

   // pointer advance
   always_comb begin
      at_last  = (wp == LAST_SLOT);
      wp_next  = at_last ? '0 : wp + 1'b1;
      ptr_next = {wrapped | at_last, wp_next};
      ptr_we   = s1_valid_ff && !err;
   end

   always_comb begin
      s2_in.valid  = s1_valid_ff;
      s2_in.err    = err;
      s2_in.live   = wrapped || (wp_ext >= dl);
      s2_in.last   = s1_req_ff.last_in;
      s2_in.sample = s1_req_ff.sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pvalid_ff   <= '0;
         pw_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s1_req_ff    <= req;
         s1_pvalid_ff <= pvalid_ff[rd_ch];
         if (ptr_we) begin
            pvalid_ff[s1_ch] <= 1'b1;
         end
         pw_valid_ff <= ptr_we;
         pw_ch_ff    <= s1_ch;
         pw_ptr_ff   <= ptr_next;
         s2_ff       <= s2_in;
         s2_raddr_ff <= raddr;
         s2_waddr_ff <= waddr;
      end
   end

   assign s1_busy     = s1_valid_ff;
   assign dly_rd_addr = raddr;
   assign s2          = s2_ff;
   assign s2_raddr    = s2_raddr_ff;
   assign s2_waddr    = s2_waddr_ff;

   // every accepted beat shows up in the pointer stage next cycle
   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not reach pointer stage");

   // pointer state only changes for channels that exist
   a_ptr_we_range: assert property (@(posedge clock) disable iff (reset)
      ptr_we |-> (32'(s1_req_ff.channel) < MAX_CHANNELS))
      else $error("pointer write for nonexistent channel");

endmodule

>>> rtl/core/cmbf_mac.sv
// Multiply-add stage: delayed sample select, gain product, rounding, saturation, line write.
`timescale 1ns / 1ps

module cmbf_mac import cmbf_pkg::*; #(
   parameter int AW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  stage_type     s2,
   input  logic [AW-1:0] s2_raddr,
   input  logic [AW-1:0] s2_waddr,
   input  logic [SAMPLE_W-1:0] dly_rd_data,
   output logic          dly_wr_en,
   output logic [AW-1:0] dly_wr_addr,
   output logic [SAMPLE_W-1:0] dly_wr_data,
   output logic          res_valid,
   output rsp_type       res
);

   localparam logic [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(1) << (FRAC_W - 1);

   // last line write, for a read issued at the same edge
   logic                       lw_valid_ff;
   logic [AW-1:0]              lw_addr_ff;
   logic [SAMPLE_W-1:0]        lw_data_ff;

   logic                       res_valid_ff;
   rsp_type                    res_ff, res_in;

   logic signed [SAMPLE_W-1:0] d_sel, y;
   logic signed [PROD_W-1:0]   prod_full;
   logic        [PROD_W:0]     rnd;
   logic        [Q_W-1:0]      q;
   logic        [SUM_W-1:0]    sum;
   logic                       fwd_hit;

   // delayed sample: forwarded, stored, or never written
   always_comb begin
      fwd_hit = lw_valid_ff && (lw_addr_ff == s2_raddr);
      priority if (fwd_hit) begin
         d_sel = lw_data_ff;
      end else if (s2.live) begin
         d_sel = dly_rd_data;
      end else begin
         d_sel = '0;
      end
   end

   // y = sat(x + floor((gain * d + half) / 2^15))
   always_comb begin
      prod_full = cfg.gain * d_sel;
      rnd       = {prod_full[PROD_W-1], prod_full} + ROUND_BIAS;
      q         = rnd[PROD_W:FRAC_W];
      sum       = {{(SUM_W - SAMPLE_W){s2.sample[SAMPLE_W-1]}}, s2.sample}
                + {q[Q_W-1], q};
      if (sum[SUM_W-1:SAMPLE_W-1] == {(SUM_W - SAMPLE_W + 1){sum[SUM_W-1]}}) begin
         y = sum[SAMPLE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         y = SAMPLE_MIN;
      end else begin
         y = SAMPLE_MAX;
      end
   end

   // line write and result beat
   always_comb begin
      dly_wr_en   = s2.valid && !s2.err;
      dly_wr_addr = s2_waddr;
      dly_wr_data = (cfg.mode == MODE_IIR) ? y : s2.sample;

      res_in.last_out      = s2.last;
      res_in.channel_error = s2.err;
      res_in.sample_out    = s2.err ? s2.sample : y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff  <= dly_wr_en;
         lw_addr_ff   <= dly_wr_addr;
         lw_data_ff   <= dly_wr_data;
         res_valid_ff <= s2.valid;
         res_ff       <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   // a forwarded entry was written, so the fill state must call it live
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      (s2.valid && !s2.err && fwd_hit) |-> s2.live)
      else $error("forwarded delay entry marked as never written");

endmodule

>>> rtl/core/cmbf_outq.sv
// Output queue holding finished result beats until the receiver takes them.
`timescale 1ns / 1ps

module cmbf_outq import cmbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_type               push_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   output logic [OUTQ_CNT_W-1:0] count
);

   rsp_type                 mem_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUTQ_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

>>> rtl/core/multichannel_comb_filter.sv
// Top level of the multichannel comb filter.
`timescale 1ns / 1ps

// Multichannel comb filter: each beat carries one Q1.15 sample and its channel;
// the result is x + round(gain * d), saturated, where d is the entry written
// delay_len samples earlier on that channel (input in FIR mode, output in IIR
// mode). One sample per cycle is accepted while req_stall is low, on any mix of
// channels; a result passes the pointer stage, the multiply-add stage and the
// result register into the output queue, which offers it. The rate is set by
// the multiply-add stage, which reads the delay RAM and writes it back in the
// same pass, with a one-deep bypass for an entry written the cycle before.
// Delay lines read as zero until written: a per-channel pointer and wrap flag
// track which entries are filled, so there is no clearing pass after reset.
// Finished results wait in an eight-beat queue; input stall rises once the
// queued results plus the beats in the three pipeline stages reach eight, so
// every beat in flight has a slot. A channel at or above num_channels or
// MAX_CHANNELS passes its sample through, flags channel_error and changes no
// state. Write configuration only while no beats are in flight.
module multichannel_comb_filter import cmbf_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_DELAY    = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_CHANNELS * MAX_DELAY);

   cfg_type                 cfg_ff, cfg_in;
   logic                    req_accept;
   logic                    s1_busy;
   stage_type               s2;
   logic [AW-1:0]           s2_raddr, s2_waddr, dly_rd_addr, dly_wr_addr;
   logic [SAMPLE_W-1:0]     dly_rd_data, dly_wr_data;
   logic                    dly_wr_en;
   logic                    res_valid;
   rsp_type                 res;
   logic [OUTQ_CNT_W-1:0]   q_count;
   logic [1:0]              inflight;
   logic [OUTQ_CNT_W:0]     credit_used;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MODE:         cfg_in.mode         = mode_type'(csr_wdata[0]);
            CSR_GAIN:         cfg_in.gain         = csr_wdata[GAIN_W-1:0];
            CSR_DELAY_LEN:    cfg_in.delay_len    = csr_wdata[DLEN_W-1:0];
            CSR_NUM_CHANNELS: cfg_in.num_channels = csr_wdata[NCH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_FIR;
         cfg_ff.gain         <= '0;
         cfg_ff.delay_len    <= DLEN_W'(1);
         cfg_ff.num_channels <= NCH_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input flow control: beats in flight plus queued results bound by queue depth
   always_comb begin
      inflight    = 2'(s1_busy) + 2'(s2.valid) + 2'(res_valid);
      credit_used = (OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(inflight);
      req_stall   = reset || (credit_used >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
      req_accept  = req_valid && !req_stall;
   end

   cmbf_addr #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DELAY    (MAX_DELAY)
   ) u_addr (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (req_accept),
      .req         (req_payload),
      .s1_busy     (s1_busy),
      .dly_rd_addr (dly_rd_addr),
      .s2          (s2),
      .s2_raddr    (s2_raddr),
      .s2_waddr    (s2_waddr)
   );

   cmbf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_CHANNELS * MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dly_wr_en),
      .wr_addr (dly_wr_addr),
      .wr_data (dly_wr_data),
      .rd_addr (dly_rd_addr),
      .rd_data (dly_rd_data)
   );

   cmbf_mac #(
      .AW (AW)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .s2          (s2),
      .s2_raddr    (s2_raddr),
      .s2_waddr    (s2_waddr),
      .dly_rd_data (dly_rd_data),
      .dly_wr_en   (dly_wr_en),
      .dly_wr_addr (dly_wr_addr),
      .dly_wr_data (dly_wr_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   cmbf_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (res_valid),
      .push_data   (res),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .count       (q_count)
   );

   // queue can always absorb every beat still in the pipeline
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH))
      else $error("result queue overcommitted");

endmodule
